@@ design/fbpsc_pkg.sv @@
package fbpsc_pkg;

  // Speed inputs carry this many fractional bits (1/16 rpm)
  localparam int SPEED_FRAC_BITS = 4;
  localparam int Q8_SHIFT        = 8 - SPEED_FRAC_BITS;

  // Field widths
  localparam int SPEED_W = 15;
  localparam int ERR_W   = 16;
  localparam int DRIVE_W = 15;

  // Stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND    = 2'd0,
    REG_P_GAIN  = 2'd1,
    REG_P_LIMIT = 2'd2
  } reg_idx_t;

  localparam logic [13:0] BAND_RESET    = 14'd800;
  localparam logic [7:0]  P_GAIN_RESET  = 8'd51;
  localparam logic [6:0]  P_LIMIT_RESET = 7'd5;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Feed-forward: 18.733 and 7.6714 in Q8
  localparam logic signed [19:0] FF_OFFSET_Q8 = 20'sd4796;
  // round(n*256/1964) == floor((|n|*64 + 245) / 491); 1/491 by reciprocal
  localparam int FF_SCALE_SHIFT = 6;
  localparam logic [MUL_A_W-1:0] FF_BIAS = 25'd245;
  localparam int FF_RECIP_SHIFT = 34;
  localparam logic [MUL_B_W-1:0] FF_RECIP =
    26'(((64'd1 << FF_RECIP_SHIFT) + 64'd490) / 64'd491);

  localparam logic [MUL_B_W-1:0] MV_PER_PERCENT = 26'd127;
  localparam logic [13:0]        DRIVE_MAX      = 14'd12700;

endpackage

@@ design/fbpsc_mul.sv @@
module fbpsc_mul
  import fbpsc_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [PROD_W-1:0]  prod
);

  // Unsigned multiply, product registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

@@ design/flywheel_bang_bang_p_speed_ctrl.sv @@
// A result shows on the master side after its request has passed through the states
// S_PREP, S_FF, S_P, S_SUM, S_DRV and S_FIN; the sequencer runs three products
// through one shared multiplier and holds one request at a time.
// Reset (rst, synchronous, active high): registers band=800, p_gain=51, p_limit=5,
// settled flag clear, sequencer idle, no result pending.
module flywheel_bang_bang_p_speed_ctrl
  import fbpsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // {speed_b[44:30], speed_a[29:15], setpoint[14:0]}, zero padded
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // {error[30:15], drive_mv[14:0]}, zero padded
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // speed_ok[0]
  output logic                   m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_FF, S_P, S_SUM, S_DRV, S_FIN, S_OUT
  } state_t;

  state_t state;

  // Configuration
  logic [13:0] band;
  logic [7:0]  p_gain;
  logic [6:0]  p_limit;

  // Per-request working registers
  logic signed [SPEED_W-1:0] target;
  logic signed [ERR_W-1:0]   err;
  logic                      settled;
  logic                      zero_tgt;
  logic                      cut;
  logic [MUL_A_W-1:0]        ff_x;
  logic                      ff_neg;
  logic [14:0]               err_mag;
  logic signed [17:0]        ff;
  logic                      s_neg;
  logic [17:0]               s_mag;

  // Result registers
  logic signed [DRIVE_W-1:0] drive_mv;
  logic                      speed_ok;
  logic signed [ERR_W-1:0]   err_out;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  fbpsc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, err_out, drive_mv};
  assign m_tuser   = speed_ok;

  // Error at input: target minus floor average of the two speeds
  logic signed [SPEED_W-1:0] in_target, in_a, in_b;
  logic signed [ERR_W-1:0]   ab_sum;
  logic signed [ERR_W-1:0]   err_in;

  always_comb begin
    in_target = s_tdata[14:0];
    in_a      = s_tdata[29:15];
    in_b      = s_tdata[44:30];
    ab_sum    = ERR_W'(in_a) + ERR_W'(in_b);
    err_in    = ERR_W'(in_target) - $signed({ab_sum[15], ab_sum[15:1]});
  end

  // Prep step: settle flag, cut-off test, feed-forward dividend
  logic signed [19:0] ff_n;
  logic [19:0]        ff_abs;
  logic [15:0]        err_abs;
  logic signed [16:0] err_x, band_x, err_pb;
  logic               settled_next;

  always_comb begin
    ff_n    = (20'(target) <<< Q8_SHIFT) + FF_OFFSET_Q8;
    ff_abs  = ff_n[19] ? 20'(-ff_n) : 20'(ff_n);
    err_abs = err[15] ? 16'(-err) : 16'(err);
    err_x   = {err[15], err};
    band_x  = $signed({3'b000, band});
    err_pb  = err_x + band_x;
    settled_next = settled;
    if (target != '0) begin
      if (err_x >= band_x) begin
        settled_next = 1'b0;
      end
      if ((err[15] || err == '0) && !settled_next) begin
        settled_next = 1'b1;
      end
    end
  end

  // Proportional clamp and sum
  logic [23:0]        p_rnd;
  logic signed [20:0] p_raw, lim_x, p_cl;
  logic signed [18:0] s_sum;

  always_comb begin
    p_rnd = 24'(prod[22:0]) + 24'd8;
    p_raw = err[15] ? -$signed({1'b0, p_rnd[23:4]}) : $signed({1'b0, p_rnd[23:4]});
    lim_x = $signed({6'b0, p_limit, 8'b0});
    if (p_raw > lim_x) begin
      p_cl = lim_x;
    end else if (p_raw < -lim_x) begin
      p_cl = -lim_x;
    end else begin
      p_cl = p_raw;
    end
    s_sum = 19'(ff) + 19'(p_cl);
  end

  // Final rounding and saturation of drive
  logic [25:0]               d_rnd;
  logic [13:0]               d_sat;
  logic signed [DRIVE_W-1:0] d_fb, d_sel;

  always_comb begin
    d_rnd = 26'(prod[24:0]) + 26'd128;
    d_sat = (d_rnd[25:8] > 18'(DRIVE_MAX)) ? DRIVE_MAX : d_rnd[21:8];
    d_fb  = s_neg ? -$signed({1'b0, d_sat}) : $signed({1'b0, d_sat});
    if (zero_tgt || cut) begin
      d_sel = '0;
    end else if (!settled) begin
      d_sel = $signed({1'b0, DRIVE_MAX});
    end else begin
      d_sel = d_fb;
    end
  end

  // Multiplier operand select
  always_comb begin
    case (state)
      S_FF: begin
        mul_a = ff_x;
        mul_b = FF_RECIP;
      end
      S_P: begin
        mul_a = MUL_A_W'(err_mag);
        mul_b = MUL_B_W'(p_gain);
      end
      S_DRV: begin
        mul_a = MUL_A_W'(s_mag);
        mul_b = MV_PER_PERCENT;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer, configuration and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      settled  <= 1'b0;
      band     <= BAND_RESET;
      p_gain   <= P_GAIN_RESET;
      p_limit  <= P_LIMIT_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_BAND:    band    <= cfg_data;
          REG_P_GAIN:  p_gain  <= cfg_data[7:0];
          REG_P_LIMIT: p_limit <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            target <= in_target;
            err    <= err_in;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          settled  <= settled_next;
          zero_tgt <= (target == '0);
          cut      <= err_pb[16];
          ff_x     <= (MUL_A_W'(ff_abs[18:0]) << FF_SCALE_SHIFT) + FF_BIAS;
          ff_neg   <= ff_n[19];
          err_mag  <= err_abs[14:0];
          state    <= S_FF;
        end
        S_FF: begin
          state <= S_P;
        end
        S_P: begin
          ff    <= ff_neg ? -$signed({1'b0, prod[FF_RECIP_SHIFT+16:FF_RECIP_SHIFT]})
                          :  $signed({1'b0, prod[FF_RECIP_SHIFT+16:FF_RECIP_SHIFT]});
          state <= S_SUM;
        end
        S_SUM: begin
          s_neg <= s_sum[18];
          s_mag <= s_sum[18] ? 18'(-s_sum) : 18'(s_sum);
          state <= S_DRV;
        end
        S_DRV: begin
          state <= S_FIN;
        end
        S_FIN: begin
          drive_mv <= d_sel;
          speed_ok <= settled;
          err_out  <= err;
          m_tvalid <= 1'b1;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/fbpsc_chk.sv @@
module fbpsc_chk
  import fbpsc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  // One request in flight: no new request while a result is pending
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while result pending");

  // A taken request closes the input side
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still ready after request");

  // Not settled means full drive, or zero for a zero target
  a_unsettled_drive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      (m_tdata[14:0] == 15'(DRIVE_MAX) || m_tdata[14:0] == 15'd0))
    else $error("unsettled drive not full or zero");

  // Drive stays within the saturation bounds
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) <= $signed({1'b0, DRIVE_MAX}) &&
                  $signed(m_tdata[14:0]) >= -$signed({1'b0, DRIVE_MAX})))
    else $error("drive out of range");

endmodule

bind flywheel_bang_bang_p_speed_ctrl fbpsc_chk u_fbpsc_chk (.*);

@@ tb/flywheel_bang_bang_p_speed_ctrl_tb.sv @@
module flywheel_bang_bang_p_speed_ctrl_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbpsc_pkg::*;

  // Controller constants, Q8 percent
  localparam longint FF_OFS_Q8    = 4796;
  localparam longint FF_SLOPE_Q8  = 1964;
  localparam longint MV_PER_PCT   = 127;
  localparam longint DRIVE_LIM_MV = 12700;
  localparam int     SPEED_MIN    = -16384;
  localparam int     SPEED_MAX    = 16383;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_b;
    logic signed [SPEED_W-1:0] speed_a;
    logic signed [SPEED_W-1:0] target;
  } speed_sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_mv;
    logic                      speed_ok;
    logic signed [ERR_W-1:0]   error;
  } drive_result_t;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_EVERY_3RD,
    SINK_RANDOM,
    SINK_LONG_STALL
  } sink_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_BAND;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Shadow of the controller registers and settled flag
  logic [13:0] band_q  = BAND_RESET;
  logic [7:0]  gain_q  = P_GAIN_RESET;
  logic [6:0]  limit_q = P_LIMIT_RESET;
  bit          settled_q = 1'b0;

  speed_sample_t pending_q[$];
  drive_result_t drive_exp_q[$];
  int            fail_cnt = 0;
  bit            req_taken = 1'b0;

  // Sender burst state
  int burst_left = 1;
  int gap_left   = 0;

  // Receiver stall pattern state
  sink_mode_t sink_mode = SINK_ALWAYS;
  int         mode_left = 0;
  int unsigned sink_phase = 0;

  flywheel_bang_bang_p_speed_ctrl i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Round to nearest, halves away from zero; d > 0
  function automatic longint div_near(longint n, longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Expected drive for one request; advances the settled flag
  function automatic drive_result_t flywheel_predict(logic [IN_TDATA_W-1:0] d);
    longint tgt, sa, sb, avg, err, bnd, ff, pt, lim, drv;
    drive_result_t r;
    tgt = longint'($signed(d[SPEED_W-1:0]));
    sa  = longint'($signed(d[2*SPEED_W-1:SPEED_W]));
    sb  = longint'($signed(d[3*SPEED_W-1:2*SPEED_W]));
    avg = (sa + sb) >>> 1;
    err = clip(tgt - avg, -32768, 32767);
    bnd = longint'(band_q);
    drv = 0;
    if (tgt != 0) begin
      if (err >= bnd) settled_q = 1'b0;
      if (err <= 0 && !settled_q) settled_q = 1'b1;
      if (!settled_q) begin
        drv = DRIVE_LIM_MV;
      end else if (err >= -bnd) begin
        ff  = div_near(((tgt <<< Q8_SHIFT) + FF_OFS_Q8) * 256, FF_SLOPE_Q8);
        lim = longint'(limit_q) * 256;
        pt  = clip(div_near(longint'(gain_q) * err, longint'(1) << SPEED_FRAC_BITS),
                   -lim, lim);
        drv = clip(div_near((ff + pt) * MV_PER_PCT, 256), -DRIVE_LIM_MV, DRIVE_LIM_MV);
      end
    end
    r.drive_mv = drv[DRIVE_W-1:0];
    r.speed_ok = settled_q;
    r.error    = err[ERR_W-1:0];
    return r;
  endfunction

  // Random sample: mostly speeds placed around the target by a chosen error
  function automatic speed_sample_t make_sample();
    int tgt, err, avg, d, sa, sb, kind, bnd;
    speed_sample_t s;
    bnd  = int'(band_q);
    kind = $urandom_range(0, 99);
    tgt  = int'($urandom_range(0, 32767)) + SPEED_MIN;
    if (kind < 10) tgt = 0;
    if (kind < 25) begin
      sa = int'($urandom_range(0, 32767)) + SPEED_MIN;
      sb = int'($urandom_range(0, 32767)) + SPEED_MIN;
    end else begin
      if ($urandom_range(0, 1)) tgt = $urandom_range(400, 3200);
      if (tgt == 0) tgt = 1;
      if (kind < 45) begin
        case ($urandom_range(0, 6))
          0: err = bnd;
          1: err = bnd - 1;
          2: err = -bnd;
          3: err = -bnd - 1;
          4: err = 0;
          5: err = 1;
          default: err = -1;
        endcase
      end else begin
        err = int'($urandom_range(0, 4 * bnd + 200)) - (2 * bnd + 100);
      end
      avg = tgt - err;
      d   = $urandom_range(0, 40);
      sa  = avg + d + int'($urandom_range(0, 1));
      sb  = avg - d;
    end
    s.target  = SPEED_W'(tgt);
    s.speed_a = SPEED_W'(clip(sa, SPEED_MIN, SPEED_MAX));
    s.speed_b = SPEED_W'(clip(sb, SPEED_MIN, SPEED_MAX));
    return s;
  endfunction

  task automatic add_sample(int t, int a, int b);
    speed_sample_t s;
    s.target  = SPEED_W'(t);
    s.speed_a = SPEED_W'(a);
    s.speed_b = SPEED_W'(b);
    pending_q.push_back(s);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [13:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BAND:    band_q  = val;
      REG_P_GAIN:  gain_q  = val[7:0];
      REG_P_LIMIT: limit_q = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_gains(logic [13:0] b, logic [13:0] g, logic [13:0] l);
    write_reg(REG_BAND, b);
    write_reg(REG_P_GAIN, g);
    write_reg(REG_P_LIMIT, l);
  endtask

  // All requests taken and all results back, plus pipeline margin
  task automatic wait_idle();
    while (pending_q.size() != 0 || drive_exp_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Request side: predict at acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) drive_exp_q.push_back(flywheel_predict(s_tdata));
    end
  end

  // Driver: bursts of requests with random gaps
  always @(negedge clk) begin : drv_blk
    logic valid_n;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (req_taken) void'(pending_q.pop_front());
      valid_n = s_tvalid && !req_taken;
      if (!valid_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          valid_n = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      s_tvalid <= valid_n;
      if (valid_n) s_tdata <= IN_TDATA_W'(pending_q[0]);
    end
  end

  // Receiver: stall pattern that changes mode every so often
  always @(negedge clk) begin : sink_blk
    logic rdy;
    if (mode_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    sink_phase++;
    case (sink_mode)
      SINK_ALWAYS:     rdy = 1'b1;
      SINK_EVERY_3RD:  rdy = (sink_phase % 3) == 0;
      SINK_RANDOM:     rdy = 1'($urandom_range(0, 1));
      default:         rdy = (sink_phase % 24) >= 18;
    endcase
    m_tready <= rdy;
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin : mon_blk
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (drive_exp_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        want = drive_exp_q.pop_front();
        if ($signed(m_tdata[DRIVE_W-1:0]) !== want.drive_mv) begin
          $error("drive_mv: expected %0d, got %0d", want.drive_mv,
                 $signed(m_tdata[DRIVE_W-1:0]));
          fail_cnt++;
        end
        if (m_tuser !== want.speed_ok) begin
          $error("speed_ok: expected %0d, got %0d", want.speed_ok, m_tuser);
          fail_cnt++;
        end
        if ($signed(m_tdata[DRIVE_W+ERR_W-1:DRIVE_W]) !== want.error) begin
          $error("error: expected %0d, got %0d", want.error,
                 $signed(m_tdata[DRIVE_W+ERR_W-1:DRIVE_W]));
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus sequencing
  initial begin : stim_blk
    int ph, n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero target, settling, cut-off, saturation, rounding of the average
    add_sample(0, 0, 0);
    add_sample(1600, 0, 0);
    add_sample(1600, 1700, 1700);
    add_sample(1600, 1601, 1600);
    add_sample(1600, 1000, 1000);
    add_sample(1600, 3000, 3000);
    add_sample(0, SPEED_MAX, SPEED_MAX);
    add_sample(SPEED_MAX, SPEED_MIN, SPEED_MIN);
    add_sample(SPEED_MIN, SPEED_MAX, SPEED_MAX);
    add_sample(SPEED_MIN, SPEED_MIN, SPEED_MIN);
    add_sample(SPEED_MAX, SPEED_MAX, SPEED_MAX);
    add_sample(5, -1, 0);
    add_sample(-3, SPEED_MAX, SPEED_MIN);
    add_sample(-1, -1, -1);
    add_sample(1, 0, 0);
    add_sample(800, 0, 0);
    add_sample(800, 900, 900);
    add_sample(800, 1600, 1600);
    add_sample(800, 1602, 1600);
    add_sample(0, SPEED_MIN, 123);
    wait_idle();

    // Band of zero: an error of zero settles
    set_gains(14'd0, 14'd255, 14'd100);
    add_sample(1200, 1200, 1200);
    add_sample(1200, 1190, 1190);
    add_sample(1200, 1201, 1200);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gains(14'd0, 14'd255, 14'd100);
        1: set_gains(14'd16383, 14'd0, 14'd0);
        2: set_gains(14'd1, 14'd1, 14'd127);
        3: set_gains(BAND_RESET, 14'(P_GAIN_RESET), 14'(P_LIMIT_RESET));
        4: set_gains(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 255)), 14'd127);
        default: set_gains(14'($urandom_range(0, 2000)), 14'($urandom_range(0, 255)),
                           14'($urandom_range(0, 127)));
      endcase
      for (n = 0; n < 70; n++) pending_q.push_back(make_sample());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
